// ----- rtl/tpg_pkg.sv -----
// ----------------------------------------------------------------------------
// tpg_pkg: shared types and constants for the turtle plotter grid unit
// Field widths, stream word layouts, command codes, headings and the
// sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tpg_pkg;

  localparam int GRID_SIZE_DEF = 50;

  localparam int KIND_W      = 3;
  localparam int DIST_W      = 12;
  localparam int ROW_INDEX_W = 6;
  localparam int ROW_BITS_W  = 50;

  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 56;

  typedef enum logic [KIND_W-1:0] {
    KIND_PEN_UP    = 3'd0,
    KIND_PEN_DOWN  = 3'd1,
    KIND_TURN_RIGHT = 3'd2,
    KIND_TURN_LEFT = 3'd3,
    KIND_MOVE      = 3'd4,
    KIND_READOUT   = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    HEAD_EAST  = 2'd0,
    HEAD_SOUTH = 2'd1,
    HEAD_WEST  = 2'd2,
    HEAD_NORTH = 2'd3
  } heading_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_MARK,
    ST_READ,
    ST_LOAD
  } state_t;

endpackage

// ----- rtl/turtle_plotter_grid_unit.sv -----
// ----------------------------------------------------------------------------
// turtle_plotter_grid_unit: turtle plotter on a square bitmap
// One command request per input word; a single step unit walks the turtle
// cell by cell and a row memory holds the drawing.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one command per request (pen up, pen down, turn right,
//   turn left, move by a distance, readout). s_tready is high only while the
//   sequencer is idle; one command is worked at a time.
//   Output stream m_*: a readout sends GRID_SIZE words, row 0 first, with
//   m_tlast on the final row. Other commands send nothing.
//   Flow: pen and turn commands are done in the idle state. A move walks
//   one step per cycle with the pen up, or passes each step through a step
//   and a mark state with the pen down (read and write of the row memory);
//   steps stop at the grid edge. A readout passes a read state and then
//   sends one row per cycle while m_tready is high, as the single read port allows.
//   A stalled receiver holds the output register and the readout waits on
//   it; once the last row sits in the output register a new command is
//   taken. Reset clears the bitmap through per-row valid bits at once,
//   puts the turtle at row 0, column 0, facing east with the pen up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module turtle_plotter_grid_unit #(
  parameter int GRID_SIZE = tpg_pkg::GRID_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [tpg_pkg::S_TDATA_W-1:0] s_tdata,   // kind[2:0], distance[14:3], zero[15]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [tpg_pkg::M_TDATA_W-1:0] m_tdata,   // row_index[5:0], row_bits[55:6]
  output logic                          m_tlast    // last_row
);

  localparam int IDX_W = $clog2(GRID_SIZE);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(GRID_SIZE - 1);

  tpg_pkg::state_t   state, state_next;
  tpg_pkg::heading_t heading, heading_next;
  logic [IDX_W-1:0]  row_pos, row_pos_next;
  logic [IDX_W-1:0]  col_pos, col_pos_next;
  logic              pen_down, pen_down_next;
  logic [tpg_pkg::DIST_W-1:0] dist_cnt, dist_cnt_next;
  logic [IDX_W-1:0]  row_cnt, row_cnt_next;

  logic                          m_tvalid_next;
  logic [tpg_pkg::M_TDATA_W-1:0] m_tdata_next;
  logic                          m_tlast_next;

  logic [GRID_SIZE-1:0] grid_mem [GRID_SIZE];
  logic [GRID_SIZE-1:0] row_valid, row_valid_next;
  logic [GRID_SIZE-1:0] rd_row;
  logic                 rd_valid;
  logic [GRID_SIZE-1:0] rd_cur;
  logic [IDX_W-1:0]     rd_addr;
  logic                 mem_we;
  logic [GRID_SIZE-1:0] wr_row;

  tpg_pkg::kind_t kind;
  logic [tpg_pkg::DIST_W-1:0]     distance;
  logic                           at_edge;
  logic [IDX_W-1:0]               row_nx, col_nx;
  logic                           out_free;
  logic [tpg_pkg::ROW_BITS_W-1:0] row_out;

  assign kind     = tpg_pkg::kind_t'(s_tdata[tpg_pkg::KIND_W-1:0]);
  assign distance = s_tdata[tpg_pkg::KIND_W +: tpg_pkg::DIST_W];
  assign rd_cur   = rd_valid ? rd_row : '0;
  assign out_free = !m_tvalid || m_tready;

  generate
    if (GRID_SIZE >= tpg_pkg::ROW_BITS_W) begin : g_trunc
      assign row_out = rd_cur[tpg_pkg::ROW_BITS_W-1:0];
    end else begin : g_ext
      assign row_out = {{(tpg_pkg::ROW_BITS_W - GRID_SIZE){1'b0}}, rd_cur};
    end
  endgenerate

  // step unit: edge check and next cell along the heading
  always_comb begin
    row_nx  = row_pos;
    col_nx  = col_pos;
    at_edge = 1'b0;
    case (heading)
      tpg_pkg::HEAD_EAST: begin
        at_edge = (col_pos == LAST_IDX);
        col_nx  = col_pos + 1'b1;
      end
      tpg_pkg::HEAD_SOUTH: begin
        at_edge = (row_pos == LAST_IDX);
        row_nx  = row_pos + 1'b1;
      end
      tpg_pkg::HEAD_WEST: begin
        at_edge = (col_pos == '0);
        col_nx  = col_pos - 1'b1;
      end
      default: begin
        at_edge = (row_pos == '0);
        row_nx  = row_pos - 1'b1;
      end
    endcase
  end

  always_comb begin
    state_next     = state;
    heading_next   = heading;
    row_pos_next   = row_pos;
    col_pos_next   = col_pos;
    pen_down_next  = pen_down;
    dist_cnt_next  = dist_cnt;
    row_cnt_next   = row_cnt;
    m_tvalid_next  = m_tvalid && !m_tready;
    m_tdata_next   = m_tdata;
    m_tlast_next   = m_tlast;
    row_valid_next = row_valid;
    s_tready       = 1'b0;
    rd_addr        = row_cnt;
    mem_we         = 1'b0;
    wr_row         = rd_cur | ({{(GRID_SIZE-1){1'b0}}, 1'b1} << col_pos);

    unique case (state)
      tpg_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          case (kind)
            tpg_pkg::KIND_PEN_UP:     pen_down_next = 1'b0;
            tpg_pkg::KIND_PEN_DOWN:   pen_down_next = 1'b1;
            tpg_pkg::KIND_TURN_RIGHT: heading_next = tpg_pkg::heading_t'(heading + 2'd1);
            tpg_pkg::KIND_TURN_LEFT:  heading_next = tpg_pkg::heading_t'(heading - 2'd1);
            tpg_pkg::KIND_MOVE: begin
              dist_cnt_next = distance;
              state_next    = tpg_pkg::ST_STEP;
            end
            tpg_pkg::KIND_READOUT: begin
              row_cnt_next = '0;
              state_next   = tpg_pkg::ST_READ;
            end
            default: ;
          endcase
        end
      end
      tpg_pkg::ST_STEP: begin
        rd_addr = row_nx;
        if (dist_cnt == '0 || at_edge) begin
          state_next = tpg_pkg::ST_IDLE;
        end else begin
          row_pos_next  = row_nx;
          col_pos_next  = col_nx;
          dist_cnt_next = dist_cnt - 1'b1;
          if (pen_down) state_next = tpg_pkg::ST_MARK;
        end
      end
      tpg_pkg::ST_MARK: begin
        mem_we                  = 1'b1;
        row_valid_next[row_pos] = 1'b1;
        state_next              = tpg_pkg::ST_STEP;
      end
      tpg_pkg::ST_READ: begin
        state_next = tpg_pkg::ST_LOAD;
      end
      tpg_pkg::ST_LOAD: begin
        if (out_free) begin
          m_tvalid_next = 1'b1;
          m_tdata_next  = {row_out, tpg_pkg::ROW_INDEX_W'(row_cnt)};
          m_tlast_next  = (row_cnt == LAST_IDX);
          if (row_cnt == LAST_IDX) begin
            state_next = tpg_pkg::ST_IDLE;
          end else begin
            row_cnt_next = row_cnt + 1'b1;
            rd_addr      = row_cnt + 1'b1;
          end
        end
      end
      default: state_next = tpg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tpg_pkg::ST_IDLE;
      heading   <= tpg_pkg::HEAD_EAST;
      row_pos   <= '0;
      col_pos   <= '0;
      pen_down  <= 1'b0;
      dist_cnt  <= '0;
      row_cnt   <= '0;
      m_tvalid  <= 1'b0;
      row_valid <= '0;
    end else begin
      state     <= state_next;
      heading   <= heading_next;
      row_pos   <= row_pos_next;
      col_pos   <= col_pos_next;
      pen_down  <= pen_down_next;
      dist_cnt  <= dist_cnt_next;
      row_cnt   <= row_cnt_next;
      m_tvalid  <= m_tvalid_next;
      row_valid <= row_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    m_tdata <= m_tdata_next;
    m_tlast <= m_tlast_next;
  end

  // row memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) grid_mem[row_pos] <= wr_row;
    rd_row   <= grid_mem[rd_addr];
    rd_valid <= row_valid[rd_addr];
  end

endmodule

// ----- rtl/tpg_checker.sv -----
// ----------------------------------------------------------------------------
// tpg_checker: port-level checks for the turtle plotter grid unit
// Watches the readout stream for stall holding, row order, last-row
// marking and the busy input side during a readout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpg_checker #(
  parameter int GRID_SIZE = tpg_pkg::GRID_SIZE_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [tpg_pkg::S_TDATA_W-1:0] s_tdata,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [tpg_pkg::M_TDATA_W-1:0] m_tdata,
  input logic                          m_tlast
);

  localparam logic [tpg_pkg::ROW_INDEX_W-1:0] LAST_ROW =
    tpg_pkg::ROW_INDEX_W'(GRID_SIZE - 1);

  logic [tpg_pkg::ROW_INDEX_W-1:0] row_index;
  logic                            in_req;

  assign row_index = m_tdata[tpg_pkg::ROW_INDEX_W-1:0];
  assign in_req    = s_tvalid && s_tready && (s_tdata != '1);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

  a_last_row: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (row_index == LAST_ROW)))
    else $error("last_row flag does not match row index");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !in_req)
    else $error("command request taken during a readout");

  a_row_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=>
      m_tvalid && (row_index == tpg_pkg::ROW_INDEX_W'($past(row_index) + 1'b1)))
    else $error("readout rows out of order");

endmodule

bind turtle_plotter_grid_unit tpg_checker #(.GRID_SIZE(GRID_SIZE)) u_tpg_checker (.*);
